/* rtl/core/ehtp_pkg.sv */
// ----------------------------------------------------------------------------
// ehtp_pkg
// Types, codes and reset values shared by the health test and packer blocks.
// ----------------------------------------------------------------------------
package ehtp_pkg;

  localparam int unsigned WindowSizeDef = 1024;

  localparam int unsigned OutputBytesW = 16;
  localparam int unsigned SampleCountW = 20;
  localparam int unsigned RepeatCutW   = 10;
  localparam int unsigned PropCutW     = 11;
  localparam int unsigned ByteIndexW   = 16;
  localparam int unsigned PaddrW       = 4;
  localparam int unsigned PdataW       = 32;

  localparam logic [OutputBytesW-1:0] OutputBytesRst = 16'd32;
  localparam logic [SampleCountW-1:0] SampleCountRst = 20'd256;
  localparam logic [RepeatCutW-1:0]   RepeatCutRst   = 10'd81;
  localparam logic [PropCutW-1:0]     PropCutRst     = 11'd914;

  localparam logic [1:0] RegOutputBytes = 2'd0;
  localparam logic [1:0] RegSampleCount = 2'd1;
  localparam logic [1:0] RegRepeatCut   = 2'd2;
  localparam logic [1:0] RegPropCut     = 2'd3;

  typedef enum logic [1:0] {
    StatusBusy    = 2'd0,
    StatusDone    = 2'd1,
    StatusFail    = 2'd2,
    StatusInvalid = 2'd3
  } status_e;

  typedef struct packed {
    logic [OutputBytesW-1:0] output_bytes;
    logic [SampleCountW-1:0] sample_count;
    logic [RepeatCutW-1:0]   repeat_cutoff;
    logic [PropCutW-1:0]     proportion_cutoff;
  } cfg_t;

  typedef struct packed {
    logic                  byte_valid;
    logic [7:0]            data_byte;
    logic [ByteIndexW-1:0] byte_index;
    status_e               status;
    logic                  last;
  } result_t;

endpackage

/* rtl/core/ehtp_cfg.sv */
// ----------------------------------------------------------------------------
// ehtp_cfg
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module ehtp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ehtp_pkg::PaddrW-1:0]   paddr,
  input  logic [ehtp_pkg::PdataW-1:0]   pwdata,
  output logic [ehtp_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output ehtp_pkg::cfg_t                cfg_o
);
  import ehtp_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.output_bytes      <= OutputBytesRst;
      cfg_q.sample_count      <= SampleCountRst;
      cfg_q.repeat_cutoff     <= RepeatCutRst;
      cfg_q.proportion_cutoff <= PropCutRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegOutputBytes: cfg_q.output_bytes      <= pwdata[OutputBytesW-1:0];
        RegSampleCount: cfg_q.sample_count      <= pwdata[SampleCountW-1:0];
        RegRepeatCut:   cfg_q.repeat_cutoff     <= pwdata[RepeatCutW-1:0];
        RegPropCut:     cfg_q.proportion_cutoff <= pwdata[PropCutW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegOutputBytes: prdata = PdataW'(cfg_q.output_bytes);
      RegSampleCount: prdata = PdataW'(cfg_q.sample_count);
      RegRepeatCut:   prdata = PdataW'(cfg_q.repeat_cutoff);
      RegPropCut:     prdata = PdataW'(cfg_q.proportion_cutoff);
      default:        prdata = '0;
    endcase
  end

endmodule

/* rtl/core/ehtp_health.sv */
// ----------------------------------------------------------------------------
// ehtp_health
// Repetition count and adaptive proportion tests on the raw noise bit.
// ----------------------------------------------------------------------------
module ehtp_health #(
  parameter int unsigned WINDOW_SIZE = ehtp_pkg::WindowSizeDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              sample_bit_i,
  input  logic                              update_i,
  input  logic                              clear_i,
  input  logic [ehtp_pkg::RepeatCutW-1:0]   repeat_cutoff_i,
  input  logic [ehtp_pkg::PropCutW-1:0]     proportion_cutoff_i,
  output logic                              pass_o
);
  import ehtp_pkg::*;

  localparam int unsigned WinW = $clog2(WINDOW_SIZE);

  logic                  have_q, prev_q, ref_q;
  logic [RepeatCutW-1:0] run_q, run_d;
  logic [PropCutW-1:0]   matches_q;
  logic [WinW-1:0]       pos_q, pos_next;

  logic                  same, rep_fail, win_start, match, prop_fail;
  logic [RepeatCutW:0]   run_inc;
  logic [PropCutW:0]     match_inc;
  logic [WinW:0]         pos_inc;

  always_comb begin
    same      = have_q & (sample_bit_i == prev_q);
    run_inc   = {1'b0, run_q} + 1'b1;
    rep_fail  = same & (run_inc >= {1'b0, repeat_cutoff_i});
    run_d     = same ? run_inc[RepeatCutW-1:0] : RepeatCutW'(1);
    win_start = (pos_q == '0);
    match     = !win_start & (sample_bit_i == ref_q);
    match_inc = {1'b0, matches_q} + 1'b1;
    prop_fail = match & (match_inc >= {1'b0, proportion_cutoff_i});
    pos_inc   = {1'b0, pos_q} + 1'b1;
    pos_next  = (pos_inc >= (WinW+1)'(WINDOW_SIZE)) ? '0 : pos_inc[WinW-1:0];
    pass_o    = !rep_fail & !prop_fail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q    <= 1'b0;
      prev_q    <= 1'b0;
      run_q     <= '0;
      ref_q     <= 1'b0;
      matches_q <= '0;
      pos_q     <= '0;
    end else if (clear_i) begin
      have_q    <= 1'b0;
      prev_q    <= 1'b0;
      run_q     <= '0;
      ref_q     <= 1'b0;
      matches_q <= '0;
      pos_q     <= '0;
    end else if (update_i) begin
      have_q <= 1'b1;
      prev_q <= sample_bit_i;
      run_q  <= run_d;
      if (win_start) begin
        ref_q     <= sample_bit_i;
        matches_q <= PropCutW'(1);
        pos_q     <= WinW'(1);
      end else begin
        if (match) begin
          matches_q <= match_inc[PropCutW-1:0];
        end
        pos_q <= pos_next;
      end
    end
  end

endmodule

/* rtl/core/ehtp_pack.sv */
// ----------------------------------------------------------------------------
// ehtp_pack
// Request bookkeeping, byte packing and result formation.
// ----------------------------------------------------------------------------
module ehtp_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                sample_bit_i,
  input  logic                pass_i,
  input  ehtp_pkg::cfg_t      cfg_i,
  output logic                keep_o,
  output logic                emit_o,
  output ehtp_pkg::result_t   result_o
);
  import ehtp_pkg::*;

  logic [SampleCountW-1:0] seen_q, seen_inc, limit;
  logic [7:0]              shift_q, shift_new;
  logic [ByteIndexW-1:0]   bytes_q;
  logic [2:0]              bit_pos;
  logic                    invalid, packing, byte_now, done;

  always_comb begin
    limit     = SampleCountW'({cfg_i.output_bytes, 3'b000});
    invalid   = (seen_q == '0) &
                ((cfg_i.output_bytes == '0) | (cfg_i.sample_count < limit));
    packing   = seen_q < limit;
    bit_pos   = seen_q[2:0];
    shift_new = shift_q | (8'(sample_bit_i) << bit_pos);
    byte_now  = packing & (bit_pos == 3'd7);
    seen_inc  = seen_q + 1'b1;
    done      = seen_inc >= cfg_i.sample_count;
    keep_o    = !invalid & pass_i & !done;
    emit_o    = invalid | !pass_i | done | byte_now;

    result_o = '{byte_valid: 1'b0, data_byte: 8'd0, byte_index: '0,
                 status: StatusBusy, last: 1'b0};
    if (invalid) begin
      result_o.status = StatusInvalid;
      result_o.last   = 1'b1;
    end else if (!pass_i) begin
      result_o.status = StatusFail;
      result_o.last   = 1'b1;
    end else begin
      if (byte_now) begin
        result_o.byte_valid = 1'b1;
        result_o.data_byte  = shift_new;
        result_o.byte_index = bytes_q;
      end
      if (done) begin
        result_o.status = StatusDone;
        result_o.last   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      shift_q <= '0;
      bytes_q <= '0;
    end else if (fire_i) begin
      if (!keep_o) begin
        seen_q  <= '0;
        shift_q <= '0;
        bytes_q <= '0;
      end else begin
        seen_q <= seen_inc;
        if (byte_now) begin
          shift_q <= '0;
          bytes_q <= bytes_q + 1'b1;
        end else if (packing) begin
          shift_q <= shift_new;
        end
      end
    end
  end

endmodule

/* rtl/core/entropy_health_test_packer.sv */
// ----------------------------------------------------------------------------
// entropy_health_test_packer
// Runs repetition count and adaptive proportion tests on raw noise bits and
// packs the passing bits of each request into bytes.
//
// One noise bit is offered per item on the sample channel; results leave on
// the result channel. Both channels move an item at a rising edge where valid
// is high and stall is low. An accepted bit is held in an input register and
// processed once the result register is free, when the tests, the byte
// packing and the request bookkeeping are evaluated together and written into
// the result register. The block takes one item in every cycle while the
// receiver does not stall; the single processing stage, whose test state is
// updated at each processed item, sets that rate. Items that neither complete
// a byte nor end a request produce no result. When the receiver stalls, the
// result register holds its item and the input register fills; the sample
// stall rises once both are occupied. Reset clears all test and packing state
// and loads the register defaults (32 bytes, 256 samples, cutoffs 81 and 914).
// The user must write registers over the APB-style port only while no item
// is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module entropy_health_test_packer #(
  parameter int unsigned WINDOW_SIZE = ehtp_pkg::WindowSizeDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ehtp_pkg::PaddrW-1:0]       paddr,
  input  logic [ehtp_pkg::PdataW-1:0]       pwdata,
  output logic [ehtp_pkg::PdataW-1:0]       prdata,
  output logic                              pready,
  input  logic                              sample_valid_i,
  output logic                              sample_stall_o,
  input  logic                              sample_bit_i,
  output logic                              result_valid_o,
  input  logic                              result_stall_i,
  output logic                              byte_valid_o,
  output logic [7:0]                        data_byte_o,
  output logic [ehtp_pkg::ByteIndexW-1:0]   byte_index_o,
  output logic [1:0]                        status_o,
  output logic                              last_o
);
  import ehtp_pkg::*;

  cfg_t    cfg;
  result_t result, result_q;
  logic    in_valid_q, bit_q, out_valid_q;
  logic    out_free, fire, accept, pass, keep, emit;

  assign out_free       = !out_valid_q | !result_stall_i;
  assign fire           = in_valid_q & out_free;
  assign sample_stall_o = in_valid_q & !fire;
  assign accept         = sample_valid_i & !sample_stall_o;

  ehtp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ehtp_health #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_health (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .sample_bit_i        (bit_q),
    .update_i            (fire & keep),
    .clear_i             (fire & !keep),
    .repeat_cutoff_i     (cfg.repeat_cutoff),
    .proportion_cutoff_i (cfg.proportion_cutoff),
    .pass_o              (pass)
  );

  ehtp_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .sample_bit_i (bit_q),
    .pass_i       (pass),
    .cfg_i        (cfg),
    .keep_o       (keep),
    .emit_o       (emit),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= fire & emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bit_q <= sample_bit_i;
    end
    if (out_free) begin
      result_q <= result;
    end
  end

  assign result_valid_o = out_valid_q;
  assign byte_valid_o   = result_q.byte_valid;
  assign data_byte_o    = result_q.data_byte;
  assign byte_index_o   = result_q.byte_index;
  assign status_o       = result_q.status;
  assign last_o         = result_q.last;

endmodule

/* sim/ehtp_checker.sv */
// ----------------------------------------------------------------------------
// ehtp_checker
// Watches the sample, result and register ports of the health test packer.
// It keeps its own copy of the registers and of the test and packing state,
// and works out the results that each accepted sample must cause. Each
// accepted result is compared field by field with the oldest result still
// expected. The failure count and the number of results still due are passed
// to the testbench top.
// ----------------------------------------------------------------------------
module ehtp_checker #(
  parameter int unsigned WINDOW_SIZE = ehtp_pkg::WindowSizeDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ehtp_pkg::PaddrW-1:0]     paddr,
  input  logic [ehtp_pkg::PdataW-1:0]     pwdata,
  input  logic                            pready,
  input  logic                            sample_valid_i,
  input  logic                            sample_stall_i,
  input  logic                            sample_bit_i,
  input  logic                            result_valid_i,
  input  logic                            result_stall_i,
  input  logic                            byte_valid_i,
  input  logic [7:0]                      data_byte_i,
  input  logic [ehtp_pkg::ByteIndexW-1:0] byte_index_i,
  input  logic [1:0]                      status_i,
  input  logic                            last_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  import ehtp_pkg::*;

  cfg_t                    cfg;
  logic                    have_prev;
  logic                    prev_bit;
  logic [RepeatCutW-1:0]   run_len;
  logic                    win_ref;
  logic [PropCutW-1:0]     win_hits;
  int unsigned             win_pos;
  logic [SampleCountW-1:0] seen;
  logic [7:0]              shift_acc;
  logic [ByteIndexW-1:0]   bytes_out;

  result_t                 due_results_q[$];
  result_t                 got;
  result_t                 want;
  int                      fail_total;

  task automatic clear_request();
    have_prev = 1'b0;
    prev_bit  = 1'b0;
    run_len   = '0;
    win_ref   = 1'b0;
    win_hits  = '0;
    win_pos   = 0;
    seen      = '0;
    shift_acc = '0;
    bytes_out = '0;
  endtask

  // Updates the repetition and proportion state; returns 0 on a failing bit.
  function automatic bit passes_health(logic b);
    int unsigned nxt;
    if (have_prev && b == prev_bit) begin
      nxt = run_len + 1;
      if (nxt >= cfg.repeat_cutoff) return 1'b0;
      run_len = nxt[RepeatCutW-1:0];
    end else begin
      have_prev = 1'b1;
      prev_bit  = b;
      run_len   = RepeatCutW'(1);
    end
    if (win_pos == 0) begin
      win_ref  = b;
      win_hits = PropCutW'(1);
      win_pos  = 1;
      return 1'b1;
    end
    if (b == win_ref) begin
      nxt = win_hits + 1;
      if (nxt >= cfg.proportion_cutoff) return 1'b0;
      win_hits = nxt[PropCutW-1:0];
    end
    win_pos = (win_pos + 1 >= WINDOW_SIZE) ? 0 : win_pos + 1;
    return 1'b1;
  endfunction

  task automatic predict_sample(logic b);
    int unsigned limit;
    result_t     r;
    r     = '0;
    limit = cfg.output_bytes * 8;
    if (seen == 0 && (cfg.output_bytes == 0 || cfg.sample_count < limit)) begin
      clear_request();
      r.status = StatusInvalid;
      r.last   = 1'b1;
      due_results_q.push_back(r);
      return;
    end
    if (!passes_health(b)) begin
      clear_request();
      r.status = StatusFail;
      r.last   = 1'b1;
      due_results_q.push_back(r);
      return;
    end
    if (seen < limit) begin
      shift_acc = shift_acc | (8'(b) << seen[2:0]);
      if (seen[2:0] == 3'd7) begin
        r.byte_valid = 1'b1;
        r.data_byte  = shift_acc;
        r.byte_index = bytes_out;
        bytes_out    = bytes_out + 1'b1;
        shift_acc    = '0;
      end
    end
    seen = seen + 1'b1;
    if (seen >= cfg.sample_count) begin
      clear_request();
      r.status = StatusDone;
      r.last   = 1'b1;
      due_results_q.push_back(r);
    end else if (r.byte_valid) begin
      r.status = StatusBusy;
      due_results_q.push_back(r);
    end
  endtask

  task automatic note_failure(string what, result_t exp_r, result_t act_r);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%s: expected valid=%0b byte=%02h index=%0d status=%0d last=%0b",
               what, exp_r.byte_valid, exp_r.data_byte, exp_r.byte_index, exp_r.status,
               exp_r.last);
      $display("%s: got valid=%0b byte=%02h index=%0d status=%0d last=%0b",
               what, act_r.byte_valid, act_r.data_byte, act_r.byte_index, act_r.status,
               act_r.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.output_bytes      = OutputBytesRst;
      cfg.sample_count      = SampleCountRst;
      cfg.repeat_cutoff     = RepeatCutRst;
      cfg.proportion_cutoff = PropCutRst;
      clear_request();
      due_results_q.delete();
      fail_total   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (result_valid_i && !result_stall_i) begin
        got.byte_valid = byte_valid_i;
        got.data_byte  = data_byte_i;
        got.byte_index = byte_index_i;
        got.status     = status_e'(status_i);
        got.last       = last_i;
        if (due_results_q.size() == 0) begin
          note_failure("Unexpected result", '0, got);
        end else begin
          want = due_results_q.pop_front();
          if (got.byte_valid !== want.byte_valid || got.data_byte !== want.data_byte ||
              got.byte_index !== want.byte_index || got.status !== want.status ||
              got.last !== want.last) begin
            note_failure("Result mismatch", want, got);
          end
        end
      end
      if (sample_valid_i && !sample_stall_i) begin
        predict_sample(sample_bit_i);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[PaddrW-1:2])
          RegOutputBytes: cfg.output_bytes      = pwdata[OutputBytesW-1:0];
          RegSampleCount: cfg.sample_count      = pwdata[SampleCountW-1:0];
          RegRepeatCut:   cfg.repeat_cutoff     = pwdata[RepeatCutW-1:0];
          RegPropCut:     cfg.proportion_cutoff = pwdata[PropCutW-1:0];
          default: ;
        endcase
      end
      fail_count_o <= fail_total;
      pending_o    <= due_results_q.size();
    end
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the entropy health test packer.
//
// A short directed part covers invalid configurations, full and empty bytes,
// a byte on the final sample and both kinds of health failure. Then come the
// extreme register settings with registers changed mid-request, one long
// request that wraps the proportion window, and randomised requests with
// varied cutoffs and noise shapes. Both channels idle at random. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  import ehtp_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 700;

  localparam int unsigned NoiseUniform = 0;
  localparam int unsigned NoiseRuns    = 1;
  localparam int unsigned NoiseToggle  = 2;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [PaddrW-1:0]     paddr          = '0;
  logic [PdataW-1:0]     pwdata         = '0;
  logic [PdataW-1:0]     prdata;
  logic                  pready;
  logic                  sample_valid_i = 1'b0;
  logic                  sample_stall_o;
  logic                  sample_bit_i   = 1'b0;
  logic                  result_valid_o;
  logic                  result_stall_i = 1'b0;
  logic                  byte_valid_o;
  logic [7:0]            data_byte_o;
  logic [ByteIndexW-1:0] byte_index_o;
  logic [1:0]            status_o;
  logic                  last_o;

  logic                  quiet          = 1'b0;
  int unsigned           cycle_count    = 0;
  int                    fail_count;
  int                    pending;

  entropy_health_test_packer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_bit_i   (sample_bit_i),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .byte_valid_o   (byte_valid_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  ehtp_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .sample_valid_i (sample_valid_i),
    .sample_stall_i (sample_stall_o),
    .sample_bit_i   (sample_bit_i),
    .result_valid_i (result_valid_o),
    .result_stall_i (result_stall_i),
    .byte_valid_i   (byte_valid_o),
    .data_byte_i    (data_byte_o),
    .byte_index_i   (byte_index_o),
    .status_i       (status_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    result_stall_i <= !quiet && ($urandom_range(99) < 28);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [PdataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_bit(input logic b);
    while (!quiet && $urandom_range(99) < 28) begin
      sample_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_bit_i   <= b;
    @(posedge clk_i);
    while (sample_stall_o) @(posedge clk_i);
  endtask

  task automatic send_pattern(input logic [31:0] bits, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_bit(bits[i]);
  endtask

  task automatic send_noise(input int unsigned n, input int unsigned shape);
    logic b;
    b = 1'($urandom_range(1));
    repeat (n) begin
      case (shape)
        NoiseUniform: b = 1'($urandom_range(1));
        NoiseRuns:    if ($urandom_range(9) == 0) b = ~b;
        default:      if ($urandom_range(9) != 0) b = ~b;
      endcase
      send_bit(b);
    end
  endtask

  // Holds the sender off until every expected result has arrived and any
  // sample that causes no result has left the pipeline.
  task automatic drain();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned ob;
    int unsigned sc;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero byte count, then a sample count short of the byte count.
    reg_write(RegOutputBytes, 0);
    send_bit(1'b1);
    drain();
    reg_write(RegOutputBytes, 2);
    reg_write(RegSampleCount, 15);
    send_bit(1'b0);
    drain();

    // A full byte on the final sample, then an empty byte before the end.
    reg_write(RegOutputBytes, 1);
    reg_write(RegSampleCount, 8);
    reg_write(RegRepeatCut, 1023);
    reg_write(RegPropCut, 1024);
    send_pattern(32'hff, 8);
    drain();
    reg_write(RegSampleCount, 10);
    send_pattern(32'h200, 10);
    drain();

    // Repetition failure, then proportion failure.
    reg_write(RegRepeatCut, 2);
    send_pattern(32'h0, 2);
    drain();
    reg_write(RegRepeatCut, 1023);
    reg_write(RegPropCut, 2);
    send_pattern(32'h5, 3);
    drain();

    // Largest settings, then packing cut short and the request ended early.
    reg_write(RegOutputBytes, 65535);
    reg_write(RegSampleCount, 1048575);
    reg_write(RegRepeatCut, 1023);
    reg_write(RegPropCut, 1024);
    send_noise(40, NoiseUniform);
    drain();
    reg_write(RegOutputBytes, 1);
    send_noise(6, NoiseUniform);
    drain();
    reg_write(RegSampleCount, 0);
    send_noise(2, NoiseUniform);
    drain();

    // One long request without idling, so that the proportion window wraps.
    quiet <= 1'b1;
    reg_write(RegOutputBytes, 4);
    reg_write(RegSampleCount, 1100);
    reg_write(RegRepeatCut, 40);
    reg_write(RegPropCut, 700);
    send_noise(1100, NoiseUniform);
    drain();
    quiet <= 1'b0;

    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(9))
        0: begin
          if ($urandom_range(1) == 0) begin
            reg_write(RegOutputBytes, 0);
            reg_write(RegSampleCount, $urandom_range(0, 1048575));
          end else begin
            ob = $urandom_range(1, 65535);
            reg_write(RegOutputBytes, ob);
            reg_write(RegSampleCount, $urandom_range(0, ob * 8 - 1));
          end
          n = $urandom_range(1, 4);
        end
        1: begin
          ob = $urandom_range(1, 4);
          reg_write(RegOutputBytes, ob);
          reg_write(RegSampleCount, ob * 8 + $urandom_range(0, 16));
          if ($urandom_range(1) == 0) begin
            reg_write(RegRepeatCut, $urandom_range(0, 1));
            reg_write(RegPropCut, $urandom_range(100, 1024));
          end else begin
            reg_write(RegRepeatCut, $urandom_range(20, 1023));
            reg_write(RegPropCut, $urandom_range(0, 1));
          end
          n = $urandom_range(2, 12);
        end
        2: n = $urandom_range(10, 60);
        default: begin
          ob = $urandom_range(1, 6);
          sc = ob * 8 + $urandom_range(0, 24);
          reg_write(RegOutputBytes, ob);
          reg_write(RegSampleCount, sc);
          reg_write(RegRepeatCut, ($urandom_range(3) == 0) ? $urandom_range(2, 8)
                                                           : $urandom_range(20, 1023));
          reg_write(RegPropCut, ($urandom_range(3) == 0) ? $urandom_range(2, 12)
                                                         : $urandom_range(100, 1024));
          n = $urandom_range(10, 80);
        end
      endcase
      send_noise(n, $urandom_range(NoiseToggle));
      sent += n;
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
